### sv/jcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcs_pkg
// Shared types and byte codes for the comment stripper.
// ----------------------------------------------------------------------------
package jcs_pkg;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  // Result queue depth: one item may add two results while one waits.
  localparam int QUEUE_DEPTH = 3;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_TEXT  = 3'd0,
    MODE_STR   = 3'd1,
    MODE_ESC   = 3'd2,
    MODE_SLASH = 3'd3,
    MODE_LINE  = 3'd4,
    MODE_BLOCK = 3'd5,
    MODE_STAR  = 3'd6
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } scan_res_t;

endpackage

### sv/jsonc_comment_stripper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsonc_comment_stripper_core
// Streaming stripper for // and /* */ comments; quoted strings pass intact.
// ----------------------------------------------------------------------------
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   input   | in_valid, in_ready, in_data_byte,          | in
//           | in_end_of_text                             |
//   result  | out_item_valid, out_ready, out_byte,       | out
//           | out_valid, out_last                        |
//
// Rate: one item per cycle while in_ready is high. Each item is scanned in the
//   cycle it is accepted and its results land in a three-slot result queue that
//   drains one result per cycle while out_ready is high; an item that yields two
//   results (a held slash flushed ahead of a plain byte) fills the queue past
//   the accept threshold, so in_ready drops until the queue drains.
// Reset: synchronous; scan mode returns to text, queue empties.
// Stalls: in_ready depends only on registered queue fill, never on
//   out_ready, so input and output stall independently.
//
module jsonc_comment_stripper_core
  import jcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_text,

  output logic       out_item_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);

  scan_mode_t mode_r;
  scan_mode_t mode_nxt;
  scan_res_t  scan;
  res_t       head;
  logic       in_acc;

  assign in_acc = in_valid && in_ready;

  // Scan the incoming byte against the current mode.
  jcs_scan u_scan (
    .mode        (mode_r),
    .data_byte   (in_data_byte),
    .end_of_text (in_end_of_text),
    .mode_nxt    (mode_nxt),
    .res         (scan)
  );

  // Advance the mode only on an accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TEXT;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
    end
  end

  // Hold results until the downstream side takes them.
  jcs_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (in_acc),
    .push       (scan),
    .pop_ready  (out_ready),
    .room       (in_ready),
    .head_valid (out_item_valid),
    .head       (head)
  );

  assign out_byte  = head.data;
  assign out_valid = head.vld;
  assign out_last  = head.last;

  // End of text always produces at least one result.
  a_eot_emits : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_end_of_text |-> scan.n != 2'd0)
    else $error("end of text produced no result");

  // Mode is back to text after the final byte.
  a_eot_mode : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_end_of_text |=> mode_r == MODE_TEXT)
    else $error("mode not reset after end of text");

  // A bare end marker carries a zero byte and the last flag.
  a_bare_marker : assert property (@(posedge clk) disable iff (!rst_n)
    out_item_valid && !out_valid |-> out_byte == 8'h00 && out_last)
    else $error("malformed bare end marker");

  // A two-result item fills the queue past the accept threshold.
  a_pair_stall : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && scan.n == 2'd2 |=> !in_ready)
    else $error("queue accepted after a two-result item");

endmodule

### sv/jcs_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcs_scan
// Per-byte scanner: next mode and up to two results for one item.
// ----------------------------------------------------------------------------
module jcs_scan
  import jcs_pkg::*;
(
  input  scan_mode_t mode,
  input  logic [7:0] data_byte,
  input  logic       end_of_text,
  output scan_mode_t mode_nxt,
  output scan_res_t  res
);

  scan_mode_t m;
  logic [1:0] n;
  res_t       r0;
  res_t       r1;

  always_comb begin
    m  = mode;
    n  = 2'd0;
    r0 = '0;
    r1 = '0;
    unique case (mode)
      MODE_STR: begin
        r0 = '{data: data_byte, vld: 1'b1, last: 1'b0};
        n  = 2'd1;
        if (data_byte == CH_BACKSLASH) begin
          m = MODE_ESC;
        end else if (data_byte == CH_QUOTE) begin
          m = MODE_TEXT;
        end
      end
      MODE_ESC: begin
        r0 = '{data: data_byte, vld: 1'b1, last: 1'b0};
        n  = 2'd1;
        m  = MODE_STR;
      end
      MODE_SLASH: begin
        if (data_byte == CH_SLASH) begin
          m = MODE_LINE;
        end else if (data_byte == CH_STAR) begin
          m = MODE_BLOCK;
        end else begin
          // flush the held slash, then treat the byte as plain text
          r0 = '{data: CH_SLASH, vld: 1'b1, last: 1'b0};
          r1 = '{data: data_byte, vld: 1'b1, last: 1'b0};
          n  = 2'd2;
          m  = (data_byte == CH_QUOTE) ? MODE_STR : MODE_TEXT;
        end
      end
      MODE_LINE: begin
        if (data_byte == CH_NEWLINE) begin
          r0 = '{data: data_byte, vld: 1'b1, last: 1'b0};
          n  = 2'd1;
          m  = MODE_TEXT;
        end
      end
      MODE_BLOCK: begin
        if (data_byte == CH_STAR) begin
          m = MODE_STAR;
        end
      end
      MODE_STAR: begin
        if (data_byte == CH_SLASH) begin
          m = MODE_TEXT;
        end else if (data_byte != CH_STAR) begin
          m = MODE_BLOCK;
        end
      end
      default: begin
        if (data_byte == CH_QUOTE) begin
          r0 = '{data: data_byte, vld: 1'b1, last: 1'b0};
          n  = 2'd1;
          m  = MODE_STR;
        end else if (data_byte == CH_SLASH) begin
          m = MODE_SLASH;
        end else begin
          r0 = '{data: data_byte, vld: 1'b1, last: 1'b0};
          n  = 2'd1;
          m  = MODE_TEXT;
        end
      end
    endcase

    if (end_of_text) begin
      // a held slash only arises from text mode, so nothing was emitted yet
      if (m == MODE_SLASH) begin
        r0 = '{data: CH_SLASH, vld: 1'b1, last: 1'b0};
        n  = 2'd1;
      end
      if (n == 2'd0) begin
        r0 = '{data: 8'h00, vld: 1'b0, last: 1'b0};
        n  = 2'd1;
      end
      if (n == 2'd2) begin
        r1.last = 1'b1;
      end else begin
        r0.last = 1'b1;
      end
      m = MODE_TEXT;
    end
  end

  assign mode_nxt = m;
  assign res      = '{n: n, r0: r0, r1: r1};

endmodule

### sv/jcs_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcs_out_queue
// Small shifting result queue; head slot drives the output channel.
// ----------------------------------------------------------------------------
module jcs_out_queue
  import jcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_en,
  input  scan_res_t push,
  input  logic      pop_ready,
  output logic      room,
  output logic      head_valid,
  output res_t      head
);

  res_t              q_r   [QUEUE_DEPTH];
  res_t              q_nxt [QUEUE_DEPTH];
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic [QCNT_W-1:0] c1;
  logic [QCNT_W-1:0] push_n;
  logic              pop;

  assign head_valid = (count_r != '0);
  assign head       = q_r[0];
  assign pop        = head_valid && pop_ready;
  // accept only when two results fit without looking at the output side
  assign room       = (count_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign push_n     = push_en ? QCNT_W'(push.n) : '0;
  assign c1         = count_r - QCNT_W'(pop);
  assign count_nxt  = c1 + push_n;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && (i < QUEUE_DEPTH - 1)) begin
        q_nxt[i] = q_r[(i + 1) % QUEUE_DEPTH];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if ((push_n != '0) && (c1 == QCNT_W'(i))) begin
        q_nxt[i] = push.r0;
      end
      if ((push_n == QCNT_W'(2)) && (QCNT_W'(c1 + QCNT_W'(1)) == QCNT_W'(i))) begin
        q_nxt[i] = push.r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

### dv/jsonc_comment_stripper_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsonc_comment_stripper_core_test
// Self-checking bench for the streaming comment stripper. A scoreboard
// class tracks the scan mode and predicts the cleaned stream for every
// accepted item. Each result is checked in order against that prediction.
// Stimulus is a short directed walk through the comment and string corners,
// followed by random text built from strings, comments, held slashes and
// noise. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module jsonc_comment_stripper_core_test;
  import jcs_pkg::*;

  // Cycles with no handshake on either channel before the run is called hung.
  localparam int HANG_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1350;
  // Trailing items that are sent with no idling on either side.
  localparam int CALM_TAIL    = 200;
  // Cycles to watch for stray results once nothing is expected.
  localparam int DRAIN_CYCLES = 20;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the scan mode and holds the cleaned bytes still due.
  // --------------------------------------------------------------------------
  class strip_board;
    scan_mode_t mode;
    res_t       due_q[$];
    res_t       step_out[$];
    int         errors;
    int         items_seen;
    int         results_seen;
    int         pairs_seen;
    int         markers_seen;

    function new();
      mode         = MODE_TEXT;
      errors       = 0;
      items_seen   = 0;
      results_seen = 0;
      pairs_seen   = 0;
      markers_seen = 0;
    endfunction

    task report(input string what);
      errors++;
      $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    function void emit(input logic [7:0] b, input logic vld);
      res_t r;
      r.data = b;
      r.vld  = vld;
      r.last = 1'b0;
      step_out.push_back(r);
    endfunction

    // Byte seen in text mode: a quote opens a string, a slash is held back.
    function void plain_text(input logic [7:0] b);
      if (b == CH_QUOTE) begin
        emit(b, 1'b1);
        mode = MODE_STR;
      end else if (b == CH_SLASH) begin
        mode = MODE_SLASH;
      end else begin
        emit(b, 1'b1);
        mode = MODE_TEXT;
      end
    endfunction

    // Predict the results of one accepted item and queue them.
    function void note_item(input logic [7:0] b, input logic eot);
      res_t tail;
      step_out.delete();
      items_seen++;
      case (mode)
        MODE_STR: begin
          emit(b, 1'b1);
          if (b == CH_BACKSLASH) mode = MODE_ESC;
          else if (b == CH_QUOTE) mode = MODE_TEXT;
        end
        MODE_ESC: begin
          emit(b, 1'b1);
          mode = MODE_STR;
        end
        MODE_SLASH: begin
          if (b == CH_SLASH) begin
            mode = MODE_LINE;
          end else if (b == CH_STAR) begin
            mode = MODE_BLOCK;
          end else begin
            emit(CH_SLASH, 1'b1);
            plain_text(b);
          end
        end
        MODE_LINE: begin
          if (b == CH_NEWLINE) begin
            emit(b, 1'b1);
            mode = MODE_TEXT;
          end
        end
        MODE_BLOCK: begin
          if (b == CH_STAR) mode = MODE_STAR;
        end
        MODE_STAR: begin
          if (b == CH_SLASH) mode = MODE_TEXT;
          else if (b != CH_STAR) mode = MODE_BLOCK;
        end
        default: plain_text(b);
      endcase
      if (eot) begin
        if (mode == MODE_SLASH) emit(CH_SLASH, 1'b1);
        if (step_out.size() == 0) begin
          emit(8'h00, 1'b0);
          markers_seen++;
        end
        tail      = step_out.pop_back();
        tail.last = 1'b1;
        step_out.push_back(tail);
        mode = MODE_TEXT;
      end
      if (step_out.size() == 2) pairs_seen++;
      foreach (step_out[i]) due_q.push_back(step_out[i]);
    endfunction

    // Compare one accepted result with the oldest prediction.
    task check_result(input logic [7:0] b, input logic vld, input logic last);
      res_t want;
      results_seen++;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected result byte=%02h valid=%b last=%b", b, vld, last));
      end else begin
        want = due_q.pop_front();
        if (b !== want.data)
          report($sformatf("result %0d out_byte got %02h want %02h",
                           results_seen, b, want.data));
        if (vld !== want.vld)
          report($sformatf("result %0d out_valid got %b want %b",
                           results_seen, vld, want.vld));
        if (last !== want.last)
          report($sformatf("result %0d out_last got %b want %b",
                           results_seen, last, want.last));
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_end_of_text;
  logic       out_item_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  strip_board board = new();

  // Idling is allowed only while this is set; cleared for calm stretches
  // and for the tail of the run.
  bit idle_on;
  int hang_count;

  jsonc_comment_stripper_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_end_of_text (in_end_of_text),
    .out_item_valid (out_item_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_valid      (out_valid),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Input driver. Called at a falling edge; returns at the falling edge after
  // the item is accepted, with in_valid still high so back-to-back items
  // keep it asserted.
  // --------------------------------------------------------------------------
  task send_item(input logic [7:0] b, input logic eot);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    board.note_item(b, eot);
    @(negedge clk);
  endtask

  // Send a byte, marking end of text now and then to break the sequence.
  task send_body(input logic [7:0] b);
    send_item(b, $urandom_range(0, 39) == 0);
  endtask

  // Any byte that is not one of the special codes.
  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_SLASH || b == CH_QUOTE || b == CH_STAR ||
           b == CH_BACKSLASH || b == CH_NEWLINE);
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Random text fragments; most are well-formed, some are cut or noisy.
  // --------------------------------------------------------------------------
  task send_fragment();
    int kind;
    int len;
    logic [7:0] b;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(0, 8);
    case (kind)
      0, 1: begin
        // plain text run
        repeat (len + 1) send_body(filler_byte());
      end
      2, 3: begin
        // quoted string with escapes; comment openers inside must pass
        send_body(CH_QUOTE);
        repeat (len) begin
          case ($urandom_range(0, 5))
            0: begin
              send_body(CH_BACKSLASH);
              send_body(($urandom_range(0, 3) == 0) ? CH_QUOTE
                                                     : 8'($urandom_range(0, 255)));
            end
            1: send_body(CH_SLASH);
            2: send_body(CH_STAR);
            default: send_body(filler_byte());
          endcase
        end
        if ($urandom_range(0, 7) != 0) send_body(CH_QUOTE);
      end
      4: begin
        // line comment, usually closed by a newline
        send_body(CH_SLASH);
        send_body(CH_SLASH);
        repeat (len) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_NEWLINE);
          send_body(b);
        end
        if ($urandom_range(0, 5) != 0) send_body(CH_NEWLINE);
      end
      5, 6: begin
        // block comment with stray stars and slashes inside
        send_body(CH_SLASH);
        send_body(CH_STAR);
        repeat (len) begin
          case ($urandom_range(0, 4))
            0: send_body(CH_STAR);
            1: send_body(CH_SLASH);
            2: send_body(CH_NEWLINE);
            default: send_body(8'($urandom_range(0, 255)));
          endcase
        end
        if ($urandom_range(0, 6) != 0) begin
          repeat ($urandom_range(1, 3)) send_body(CH_STAR);
          send_body(CH_SLASH);
        end
      end
      7: begin
        // lone slash followed by something that is not an opener
        send_body(CH_SLASH);
        case ($urandom_range(0, 3))
          0: send_body(CH_QUOTE);
          1: send_body(CH_NEWLINE);
          default: send_body(filler_byte());
        endcase
      end
      default: begin
        // raw noise
        repeat (len + 1) send_body(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result side: drive out_ready at the falling edge, with stall bursts.
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check each accepted result at the rising edge.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_item_valid && out_ready)
        board.check_result(out_byte, out_valid, out_last);
    end
  end

  // Hang watchdog: count cycles with no handshake on either side.
  initial begin
    hang_count = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_item_valid && out_ready)) hang_count = 0;
      else hang_count++;
      if (hang_count >= HANG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results still due",
                 HANG_LIMIT, board.due_q.size());
        $display("jsonc_comment_stripper_core verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    // Directed walk: {end_of_text, byte}
    logic [8:0] directed [] = '{
      {1'b0, 8'h00}, {1'b0, 8'hFF},                           // byte extremes
      {1'b0, CH_QUOTE}, {1'b0, CH_BACKSLASH}, {1'b0, CH_QUOTE}, // escaped quote
      {1'b0, CH_SLASH}, {1'b0, CH_QUOTE},                      // slash in string
      {1'b0, CH_SLASH}, {1'b0, "a"},                           // held slash, two out
      {1'b0, CH_SLASH}, {1'b0, CH_STAR}, {1'b0, CH_SLASH},     // opener star not a closer
      {1'b0, CH_STAR}, {1'b0, CH_STAR}, {1'b0, CH_SLASH},      // star-star-slash closes
      {1'b1, CH_SLASH},                                        // slash flushed at end
      {1'b0, CH_SLASH}, {1'b0, CH_SLASH}, {1'b0, "q"},
      {1'b0, CH_NEWLINE},                                      // line comment keeps newline
      {1'b0, CH_SLASH}, {1'b0, CH_SLASH}, {1'b1, "x"},         // open line comment at end
      {1'b0, CH_SLASH}, {1'b0, CH_STAR}, {1'b1, "z"},          // open block comment at end
      {1'b1, "A"}                                              // end on a plain byte
    };
    int calm_from;

    idle_on        = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = 8'h00;
    in_end_of_text = 1'b0;

    // Hold reset, then release it at a falling edge.
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_on = 1'b1;
    foreach (directed[i]) send_item(directed[i][7:0], directed[i][8]);

    // Random text; idle in stretches, then run the tail with no idling.
    calm_from = board.items_seen + RANDOM_ITEMS - CALM_TAIL;
    while (board.items_seen < calm_from + CALM_TAIL) begin
      if (board.items_seen >= calm_from) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      send_fragment();
      if ($urandom_range(0, 5) == 0) send_item(filler_byte(), 1'b1);
    end
    // Close the stream so no held slash or comment lingers.
    send_item(filler_byte(), 1'b1);
    in_valid <= 1'b0;

    // Drain: wait for every predicted result, then watch for strays.
    while (board.due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items and %0d results: %0d two-result items, %0d bare end markers",
             board.items_seen, board.results_seen, board.pairs_seen, board.markers_seen);
    $display("mismatches: %0d", board.errors);
    if (board.errors == 0 && board.due_q.size() == 0) begin
      $display("jsonc_comment_stripper_core verification clean");
    end else begin
      $display("jsonc_comment_stripper_core verification failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/jcs_pkg.sv
sv/jcs_scan.sv
sv/jcs_out_queue.sv
sv/jsonc_comment_stripper_core.sv
dv/jsonc_comment_stripper_core_test.sv
